/* rtl/core/f2h_pkg.sv */
// ----------------------------------------------------------------------------
// f2h_pkg
// Shared types and constants for the single to half precision converter.
// ----------------------------------------------------------------------------
package f2h_pkg;

  localparam logic [30:0] F32_EXP_MASK    = 31'h7f800000;
  localparam logic [30:0] OVERFLOW_LIMIT  = 31'h477fefff;
  localparam logic [30:0] UNDERFLOW_LIMIT = 31'h33000001;
  localparam logic [7:0]  EXP_REBIAS      = 8'h70;
  localparam logic [7:0]  SUBNORM_BASE    = 8'h7e;
  localparam logic [4:0]  NORMAL_SHIFT    = 5'd13;
  localparam logic [15:0] HALF_QNAN       = 16'h7fff;
  localparam logic [14:0] HALF_INF        = 15'h7c00;
  localparam int          QUEUE_DEPTH     = 2;

  typedef enum logic [1:0] {
    CLS_NAN,
    CLS_INF,
    CLS_ZERO,
    CLS_FINITE
  } cls_t;

  typedef struct packed {
    cls_t        cls;
    logic        sgn;
    logic [4:0]  ex;
    logic [4:0]  sh;
    logic [23:0] frac;
  } item_t;

endpackage

/* rtl/core/fp32_to_fp16_convert_top.sv */
// ----------------------------------------------------------------------------
// fp32_to_fp16_convert_top
// IEEE single precision to half precision converter, round to nearest even.
//
// Usage: the input side is a queue write port. A transaction is taken on a
// clock edge with push high and full low. The result side is a queue read
// port: while empty is low, half_bits holds the oldest result, and it is
// removed on an edge with pop high. Each input transaction gives exactly one
// result transaction, in order.
// A pushed transaction is written into the classification queue and then
// into the rounding output register, where empty falls; an output stall
// can hold it in the queue. Throughput is one transaction per cycle while
// the receiver pops; the rounding logic is combinational. When the receiver
// stalls, the output register and the queue fill and full rises; nothing
// is lost. Reset (rst, synchronous) empties both.
// ----------------------------------------------------------------------------
module fp32_to_fp16_convert_top import f2h_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] single_bits,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] half_bits
);

  item_t front_item;
  item_t queue_item;
  logic  queue_empty;
  logic  back_ready;

  f2h_front u_front (
    .single_bits (single_bits),
    .item        (front_item)
  );

  f2h_queue #(.DEPTH(DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_item),
    .full  (full),
    .pop   (back_ready),
    .rdata (queue_item),
    .empty (queue_empty)
  );

  f2h_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (!queue_empty),
    .item      (queue_item),
    .in_ready  (back_ready),
    .empty     (empty),
    .pop       (pop),
    .half_bits (half_bits)
  );

endmodule

/* rtl/core/f2h_front.sv */
// ----------------------------------------------------------------------------
// f2h_front
// Classifies one single precision pattern and prepares shift and fraction.
// ----------------------------------------------------------------------------
module f2h_front import f2h_pkg::*; (
  input  logic [31:0] single_bits,
  output item_t       item
);

  logic [30:0] mag;
  logic [7:0]  ex8;

  assign mag = single_bits[30:0];
  assign ex8 = mag[30:23];

  always_comb begin
    item.sgn = single_bits[31];
    if (mag > F32_EXP_MASK) begin
      item.cls = CLS_NAN;
    end else if (mag > OVERFLOW_LIMIT) begin
      item.cls = CLS_INF;
    end else if (mag < UNDERFLOW_LIMIT) begin
      item.cls = CLS_ZERO;
    end else begin
      item.cls = CLS_FINITE;
    end
    if (ex8 > EXP_REBIAS) begin
      item.sh   = NORMAL_SHIFT;
      item.ex   = 5'(ex8 - EXP_REBIAS);
      item.frac = {1'b0, mag[22:0]};
    end else begin
      item.sh   = 5'(SUBNORM_BASE - ex8);
      item.ex   = '0;
      item.frac = {1'b1, mag[22:0]};
    end
  end

endmodule

/* rtl/core/f2h_queue.sv */
// ----------------------------------------------------------------------------
// f2h_queue
// Small register queue between the front and back parts.
// ----------------------------------------------------------------------------
module f2h_queue import f2h_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wdata,
  output logic  full,
  input  logic  pop,
  output item_t rdata,
  output logic  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t           mem [DEPTH];
  logic [AW-1:0]   wptr;
  logic [AW-1:0]   rptr;
  logic [AW:0]     count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule

/* rtl/core/f2h_back.sv */
// ----------------------------------------------------------------------------
// f2h_back
// Shifts, rounds to nearest even and holds the result in an output register.
// ----------------------------------------------------------------------------
module f2h_back import f2h_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  item_t       item,
  output logic        in_ready,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] half_bits
);

  logic        out_valid;
  logic [15:0] result;
  logic [23:0] mask;
  logic [23:0] rem;
  logic [23:0] half_unit;
  logic [10:0] q;
  logic [10:0] qr;
  logic [4:0]  ex;
  logic        up;

  assign mask      = (24'd1 << item.sh) - 24'd1;
  assign rem       = item.frac & mask;
  assign half_unit = (24'd1 << item.sh) >> 1;
  assign q         = 11'(item.frac >> item.sh);
  assign up        = (rem > half_unit) || ((rem == half_unit) && q[0]);

  always_comb begin
    qr = q + 11'(up);
    ex = item.ex;
    if (up && qr[9:0] == '0) begin
      ex = item.ex + 5'd1;
      qr = '0;
    end
    unique case (item.cls)
      CLS_NAN:  result = HALF_QNAN;
      CLS_INF:  result = {item.sgn, HALF_INF};
      CLS_ZERO: result = {item.sgn, 15'd0};
      default:  result = {item.sgn, ex, 10'd0} | {6'd0, qr[9:0]};
    endcase
  end

  assign in_ready = !out_valid || pop;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      half_bits <= result;
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

endmodule
